// ===== rtl/stlb_pkg.sv =====
// ----------------------------------------------------------------------------
// stlb_pkg
// Shared types and constants for the sorted table lower-bound search block.
// ----------------------------------------------------------------------------
`default_nettype none

package stlb_pkg;

   localparam int MODE_W = 2;
   localparam int DATA_W = 32;
   localparam int IDX_W  = 11;

   localparam logic [DATA_W-1:0] SIGN_FLIP = 32'h8000_0000;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_QUERY  = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_GAL_RD,
      S_GAL_CMP,
      S_BIN_SETUP,
      S_BIN_RD,
      S_BIN_CMP,
      S_FIN_CMP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic idle;
      logic done;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/stlb_ram.sv =====
// ----------------------------------------------------------------------------
// stlb_ram
// Table storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stlb_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [stlb_pkg::DATA_W-1:0] wr_data,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [stlb_pkg::DATA_W-1:0] rd_data
);
   import stlb_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/stlb_engine.sv =====
// ----------------------------------------------------------------------------
// stlb_engine
// Search sequencer: galloping probes then lower-bound binary search, one
// table read and one shared compare per step.
// ----------------------------------------------------------------------------
`default_nettype none

module stlb_engine #(
   parameter int AW    = 10,
   parameter int CNT_W = 11
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [stlb_pkg::DATA_W-1:0] key,
   input  wire logic [CNT_W-1:0]            count,
   input  wire logic                        ack,
   input  wire logic [stlb_pkg::DATA_W-1:0] rd_data,
   output logic      [AW-1:0]               rd_addr,
   output stlb_pkg::status_type             status,
   output logic      [CNT_W-1:0]            result
);
   import stlb_pkg::*;

   localparam int PRB_W = CNT_W + 1;

   state_type            state_ff, state_in;
   logic [DATA_W-1:0]    key_ff, key_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [PRB_W-1:0]     probe_ff, probe_in;
   logic [AW-1:0]        lo_ff, lo_in;
   logic [AW-1:0]        hi_ff, hi_in;
   logic [AW-1:0]        mid_ff, mid_in;
   logic [CNT_W-1:0]     res_ff, res_in;

   logic                 lt;
   logic [PRB_W-1:0]     probe_x2;
   logic [PRB_W-1:0]     n_ext;
   logic [AW-1:0]        mid_calc;

   // shared compare unit (entries and key are sign-flipped)
   assign lt       = rd_data < key_ff;
   assign probe_x2 = probe_ff << 1;
   assign n_ext    = PRB_W'(n_ff);
   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (count == '0) begin
                  state_in = S_DONE;
               end else if (count > CNT_W'(1)) begin
                  state_in = S_GAL_RD;
               end else begin
                  state_in = S_BIN_SETUP;
               end
            end
         end
         S_GAL_RD:    state_in = S_GAL_CMP;
         S_GAL_CMP: begin
            if (lt && (probe_x2 < n_ext)) begin
               state_in = S_GAL_RD;
            end else begin
               state_in = S_BIN_SETUP;
            end
         end
         S_BIN_SETUP: state_in = S_BIN_RD;
         S_BIN_RD: begin
            if (lo_ff < hi_ff) begin
               state_in = S_BIN_CMP;
            end else begin
               state_in = S_FIN_CMP;
            end
         end
         S_BIN_CMP:   state_in = S_BIN_RD;
         S_FIN_CMP:   state_in = S_DONE;
         S_DONE: begin
            if (ack) begin
               state_in = S_IDLE;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      status.idle = 1'b0;
      status.done = 1'b0;
      rd_addr     = lo_ff;
      case (state_ff)
         S_IDLE:   status.idle = 1'b1;
         S_GAL_RD: rd_addr = probe_ff[AW-1:0];
         S_BIN_RD: rd_addr = (lo_ff < hi_ff) ? mid_calc : lo_ff;
         S_DONE:   status.done = 1'b1;
         default:  rd_addr = lo_ff;
      endcase
   end

   always_comb begin
      key_in   = key_ff;
      n_in     = n_ff;
      probe_in = probe_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      res_in   = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in   = key ^ SIGN_FLIP;
               n_in     = count;
               probe_in = PRB_W'(1);
               res_in   = '0;
            end
         end
         S_GAL_CMP: begin
            if (lt) begin
               probe_in = probe_x2;
            end
         end
         S_BIN_SETUP: begin
            lo_in = AW'(probe_ff >> 1);
            hi_in = (probe_ff < n_ext) ? AW'(probe_ff) : AW'(n_ff - CNT_W'(1));
         end
         S_BIN_RD:  mid_in = mid_calc;
         S_BIN_CMP: begin
            if (lt) begin
               lo_in = mid_ff + AW'(1);
            end else begin
               hi_in = mid_ff;
            end
         end
         S_FIN_CMP: res_in = lt ? n_ff : CNT_W'(lo_ff);
         default:   res_in = res_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      key_ff   <= key_in;
      n_ff     <= n_in;
      probe_ff <= probe_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      res_ff   <= res_in;
   end

   assign result = res_ff;

endmodule

`default_nettype wire

// ===== rtl/sorted_table_lower_bound_search.sv =====
// ----------------------------------------------------------------------------
// sorted_table_lower_bound_search
// Table of signed 32-bit entries with clear, append and lower-bound query.
//
//   channel  dir  tdata                  tuser
//   req_     in   [31:0] value           [1:0] mode (0 clear,1 append,2 query)
//   rsp_     out  [10:0] index (pad 16)  [0] overflow
//
// Clear and append complete as the word is accepted. A query runs galloping
// probes, then binary steps, each step one read of the table RAM. Not ready
// while a query runs. Sync active-high reset empties the table; entries are
// not cleared. A waiting result holds off the next word until rsp_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_lower_bound_search #(
   parameter int DEPTH = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic [1:0]  req_tuser,   // [1:0] mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [10:0] index, [15:11] zero
   output logic      [0:0]  rsp_tuser    // [0] overflow
);
   import stlb_pkg::*;

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   status_type        eng_status;
   logic [CNT_W-1:0]  eng_result;
   logic [AW-1:0]     rd_addr;
   logic [DATA_W-1:0] rd_data;

   logic              out_free;
   logic              accept;
   logic              has_room;
   mode_type          mode;
   logic              wr_en;

   assign mode       = mode_type'(req_tuser);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = eng_status.idle && out_free;
   assign accept     = req_tvalid && req_tready;
   assign has_room   = count_ff < CNT_W'(DEPTH);
   assign wr_en      = accept && (mode == MODE_APPEND) && has_room;

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_index_in = rsp_index_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (accept) begin
         case (mode)
            MODE_CLEAR:  count_in = '0;
            MODE_APPEND: begin
               rsp_valid_in = 1'b1;
               rsp_index_in = IDX_W'(count_ff);
               rsp_ovf_in   = !has_room;
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            default:     count_in = count_ff;
         endcase
      end
      if (eng_status.done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = IDX_W'(eng_result);
         rsp_ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff <= rsp_index_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   stlb_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_tdata ^ SIGN_FLIP),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   stlb_engine #(
      .AW    (AW),
      .CNT_W (CNT_W)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && (mode == MODE_QUERY)),
      .key     (req_tdata),
      .count   (count_ff),
      .ack     (out_free),
      .rd_data (rd_data),
      .rd_addr (rd_addr),
      .status  (eng_status),
      .result  (eng_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - IDX_W){1'b0}}, rsp_index_ff};
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

`default_nettype wire

// ===== tb/sorted_table_lower_bound_search_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_lower_bound_search_test
// Self-checking bench for the sorted table lower-bound search block. Words
// clear the table, append entries or query a key. A local copy of the table
// follows every accepted word and works out the expected index and overflow
// flag, which the response checker compares in order. Directed cases, a full
// table with overflow, then random sorted sessions with noise, both sides
// stalling at random except in sessions 4 to 9.
// ----------------------------------------------------------------------------

module sorted_table_lower_bound_search_test;

   import stlb_pkg::*;

   localparam int TABLE_DEPTH  = 1024;
   localparam int WORD_TARGET  = 1900;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 100;
   localparam int GAP_PCT      = 21;

   localparam logic [31:0] KEY_MIN = 32'h8000_0000;
   localparam logic [31:0] KEY_MAX = 32'h7fff_ffff;

   typedef struct {
      logic [IDX_W-1:0] index;
      logic             overflow;
   } answer_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] value
   logic [1:0]  req_tuser;   // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [10:0] index, [15:11] zero
   logic [0:0]  rsp_tuser;   // [0] overflow

   // table copy, entries kept with the sign bit flipped
   logic [31:0] shadow_table [TABLE_DEPTH];
   int unsigned shadow_count;
   answer_type  pending_answers [$];
   int          mismatch_count;
   int          words_sent;
   bit          gaps_on;
   int          quiet_cycles;

   sorted_table_lower_bound_search #(
      .DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // galloping probes, then lower-bound bisection between the last two
   function automatic logic [IDX_W-1:0] lower_bound_of(input logic [31:0] key);
      int unsigned n;
      int unsigned probe;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      n = shadow_count;
      if (n == 0) return '0;
      probe = 1;
      while (probe < n && shadow_table[probe] < key) probe = probe * 2;
      lo = probe / 2;
      hi = (probe < n) ? probe : n - 1;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (key <= shadow_table[mid]) hi = mid;
         else lo = mid + 1;
      end
      return (shadow_table[lo] >= key) ? lo[IDX_W-1:0] : n[IDX_W-1:0];
   endfunction

   function automatic void track_table_word(input mode_type mode, input logic [31:0] value);
      answer_type  ans;
      logic [31:0] key;
      key = value ^ SIGN_FLIP;
      ans.overflow = 1'b0;
      case (mode)
         MODE_CLEAR: begin
            shadow_count = 0;
         end
         MODE_APPEND: begin
            ans.index = shadow_count[IDX_W-1:0];
            if (shadow_count < TABLE_DEPTH) begin
               shadow_table[shadow_count] = key;
               shadow_count++;
            end else begin
               ans.overflow = 1'b1;
            end
            pending_answers.push_back(ans);
         end
         MODE_QUERY: begin
            ans.index = lower_bound_of(key);
            pending_answers.push_back(ans);
         end
         default: ;
      endcase
   endfunction

   task automatic send_word(input mode_type mode, input logic [31:0] value);
      while (gaps_on && $urandom_range(99) < GAP_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= value;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      track_table_word(mode, value);
      words_sent++;
   endtask

   task automatic wait_for_answers();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // response side: random stalls, checked at negedge before the accepting edge
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
      end
   end

   always @(negedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected word index=%0d overflow=%0d", $time,
                     rsp_tdata[IDX_W-1:0], rsp_tuser[0]);
            mismatch_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[IDX_W-1:0] !== want.index) begin
               $display("%0t: index mismatch expected %0d actual %0d", $time,
                        want.index, rsp_tdata[IDX_W-1:0]);
               mismatch_count++;
            end
            if (rsp_tuser[0] !== want.overflow) begin
               $display("%0t: overflow mismatch expected %0d actual %0d", $time,
                        want.overflow, rsp_tuser[0]);
               mismatch_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic test_directed();
      send_word(MODE_QUERY, KEY_MIN);   // empty table
      send_word(MODE_QUERY, KEY_MAX);
      send_word(MODE_APPEND, KEY_MIN);
      send_word(MODE_APPEND, 32'hffff_ffff);
      send_word(MODE_APPEND, 32'd0);
      send_word(MODE_APPEND, KEY_MAX);
      send_word(MODE_QUERY, KEY_MIN);
      send_word(MODE_QUERY, KEY_MIN + 1);
      send_word(MODE_QUERY, 32'd0);
      send_word(MODE_QUERY, 32'd1);
      send_word(MODE_QUERY, KEY_MAX);
      send_word(MODE_NONE, $urandom());
      send_word(MODE_QUERY, 32'hffff_ffff);
      send_word(MODE_CLEAR, $urandom());
      send_word(MODE_QUERY, 32'd0);
      send_word(MODE_APPEND, 32'd5);    // duplicates
      send_word(MODE_APPEND, 32'd5);
      send_word(MODE_APPEND, 32'd5);
      send_word(MODE_QUERY, 32'd5);
      send_word(MODE_QUERY, 32'd6);
      send_word(MODE_CLEAR, 32'd0);
      send_word(MODE_APPEND, 32'd10);   // unsorted
      send_word(MODE_APPEND, 32'd1);
      send_word(MODE_APPEND, 32'd20);
      send_word(MODE_APPEND, 32'd3);
      send_word(MODE_QUERY, 32'd5);
   endtask

   task automatic test_full_table();
      longint      cur;
      logic [31:0] vals [$];
      send_word(MODE_CLEAR, 32'd0);
      wait_for_answers();
      cur = -2147483648;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         vals.push_back(cur[31:0]);
         send_word(MODE_APPEND, cur[31:0]);
         cur += $urandom_range(4000000);
      end
      send_word(MODE_APPEND, KEY_MAX);   // dropped
      send_word(MODE_APPEND, $urandom());
      send_word(MODE_QUERY, KEY_MAX);
      send_word(MODE_QUERY, KEY_MIN);
      for (int i = 0; i < 16; i++) begin
         send_word(MODE_QUERY, vals[$urandom_range(TABLE_DEPTH - 1)] + $urandom_range(2) - 1);
      end
      send_word(MODE_QUERY, vals[TABLE_DEPTH - 1]);
      send_word(MODE_QUERY, vals[TABLE_DEPTH - 1] + 1);
      send_word(MODE_CLEAR, 32'd0);
   endtask

   task automatic test_random_sessions();
      int          session;
      int          size;
      int          span;
      int          queries;
      longint      cur;
      logic [31:0] vals [$];
      logic [31:0] key;
      session = 0;
      while (words_sent < WORD_TARGET) begin
         gaps_on = !(session >= 4 && session < 10);
         vals.delete();
         send_word(MODE_CLEAR, $urandom());
         case ($urandom_range(19))
            0:       size = 0;
            1:       size = $urandom_range(1, 2);
            2:       size = $urandom_range(100, 300);
            default: size = $urandom_range(3, 40);
         endcase
         case ($urandom_range(3))
            0:       span = 1;
            1:       span = 16;
            2:       span = 65536;
            default: span = 1 << 24;
         endcase
         cur = longint'($signed($urandom()));
         for (int i = 0; i < size; i++) begin
            if (cur > 2147483647) cur = 2147483647;
            vals.push_back(cur[31:0]);
            send_word(MODE_APPEND, cur[31:0]);
            cur += $urandom_range(span);
         end
         queries = $urandom_range(1, size + 4);
         for (int q = 0; q < queries; q++) begin
            if ($urandom_range(9) == 0) begin
               case ($urandom_range(2))
                  0: send_word(MODE_NONE, $urandom());
                  1: send_word(MODE_APPEND, $urandom());
                  default: begin
                     if (cur > 2147483647) cur = 2147483647;
                     vals.push_back(cur[31:0]);
                     send_word(MODE_APPEND, cur[31:0]);
                  end
               endcase
            end else begin
               if (vals.size() == 0) key = $urandom();
               else key = vals[$urandom_range(vals.size() - 1)];
               case ($urandom_range(5))
                  2:       key = key - 1;
                  3:       key = key + 1;
                  4:       key = $urandom_range(1) ? KEY_MIN : KEY_MAX;
                  5:       key = $urandom();
                  default: ;
               endcase
               send_word(MODE_QUERY, key);
            end
         end
         session++;
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = MODE_CLEAR;
      shadow_count   = 0;
      mismatch_count = 0;
      words_sent     = 0;
      quiet_cycles   = 0;
      gaps_on        = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_random_sessions();
      wait_for_answers();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/stlb_pkg.sv
rtl/stlb_ram.sv
rtl/stlb_engine.sv
rtl/sorted_table_lower_bound_search.sv
tb/sorted_table_lower_bound_search_test.sv
